>>> rtl/lps_pkg.sv
// shared types, constants and helpers of the led panel frame scanner
package lps_pkg;

    localparam int MAX_PIXELS_DEF = 4096;
    localparam int QUEUE_DEPTH    = 4;
    localparam int COLOR_W        = 24;
    localparam int IDX_W          = 21;
    localparam int PADDR_W        = 5;
    localparam int PDATA_W        = 32;

    localparam logic [1:0] MODE_PLAIN   = 2'd0;
    localparam logic [1:0] MODE_PATTERN = 2'd1;
    localparam logic [1:0] MODE_EMIT    = 2'd2;
    localparam logic [1:0] MODE_NONE    = 2'd3;

    typedef enum logic [2:0] {
        REG_PANEL_WIDTH,
        REG_PANEL_HEIGHT,
        REG_PANELS_ACROSS,
        REG_PANELS_DOWN,
        REG_SERPENTINE,
        REG_FIRST_ROW_L2R,
        REG_REPLACE_COLOR,
        REG_OVERLAY_ONLY
    } t_reg;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_ZERO
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   addr;
        logic [COLOR_W-1:0] data;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic [6:0]         pw;
        logic [6:0]         ph;
        logic [4:0]         pa;
        logic [4:0]         pd;
        logic [10:0]        w;
        logic [10:0]        h;
        logic               serp;
        logic               l2r;
        logic [COLOR_W-1:0] repl;
        logic               ovl;
    } t_cfg;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

    function automatic logic [6:0] f_clamp(input logic [6:0] v, input logic [6:0] hi);
        logic [6:0] r;
        r = v;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

endpackage

>>> rtl/lps_ram.sv
// generic single port ram with registered read
module lps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_addr,
    input  logic [WIDTH-1:0]                       i_wdata,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

>>> rtl/lps_front.sv
// front end: accepts items, maps coordinates and runs the chain scan counters
module lps_front #(
    parameter int MAX_PIXELS = lps_pkg::MAX_PIXELS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lps_pkg::t_cfg i_cfg,
    input  logic          i_restart,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_mode,
    input  logic [9:0]    i_pixel_x,
    input  logic [9:0]    i_pixel_y,
    input  logic [7:0]    i_pattern_col,
    input  logic [7:0]    i_pattern_row,
    input  logic [23:0]   i_pixel_color,
    input  logic          i_q_full,
    output logic          o_push,
    output lps_pkg::t_cmd o_cmd
);
    import lps_pkg::*;

    logic               r_v;
    logic [1:0]         r_mode;
    logic [9:0]         r_x;
    logic [9:0]         r_y;
    logic [7:0]         r_pc;
    logic [7:0]         r_pr;
    logic [COLOR_W-1:0] r_color;

    logic [5:0] r_step;
    logic [5:0] r_row;
    logic [3:0] r_pcol;
    logic [3:0] r_prow;
    logic [9:0] r_x0;
    logic [9:0] r_y0;

    logic               accept;
    logic               consume;
    logic               emit;
    logic [10:0]        tx;
    logic [10:0]        ty;
    logic               l2r;
    logic [6:0]         col;
    logic [9:0]         sx;
    logic [9:0]         sy;
    logic [9:0]         ax;
    logic [9:0]         ay;
    logic [IDX_W-1:0]   prod;
    logic [IDX_W-1:0]   idx;
    logic               in_range;
    logic               in_store;
    logic               wr_do;
    logic [COLOR_W-1:0] wr_color;
    logic               step_wrap;
    logic               row_wrap;
    logic               pcol_wrap;
    logic               prow_wrap;

    assign consume = r_v && !i_q_full;
    assign o_ready = !r_v || consume;
    assign accept  = i_valid && o_ready;
    assign emit    = consume && (r_mode == MODE_EMIT);

    always_comb begin
        if (r_mode == MODE_PATTERN) begin
            tx = {1'b0, r_x} + {3'b0, r_pc};
            ty = {1'b0, r_y} + {3'b0, r_pr};
        end else begin
            tx = {1'b0, r_x};
            ty = {1'b0, r_y};
        end
        l2r = i_cfg.l2r ^ (i_cfg.serp & r_row[0]);
        col = l2r ? {1'b0, r_step} : (i_cfg.pw - 7'd1 - {1'b0, r_step});
        sx  = r_x0 + {3'b0, col};
        sy  = r_y0 + {4'b0, r_row};
        ax  = (r_mode == MODE_EMIT) ? sx : tx[9:0];
        ay  = (r_mode == MODE_EMIT) ? sy : ty[9:0];
        prod = IDX_W'(ay) * IDX_W'(i_cfg.w);
        idx  = prod + IDX_W'(ax);
        in_range = (tx < i_cfg.w) && (ty < i_cfg.h);
        in_store = idx < IDX_W'(MAX_PIXELS);

        step_wrap = ({1'b0, r_step} + 7'd1) >= i_cfg.pw;
        row_wrap  = ({1'b0, r_row} + 7'd1) >= i_cfg.ph;
        pcol_wrap = ({1'b0, r_pcol} + 5'd1) >= i_cfg.pa;
        prow_wrap = ({1'b0, r_prow} + 5'd1) >= i_cfg.pd;

        wr_do    = 1'b0;
        wr_color = r_color;
        o_cmd.op   = OP_WRITE;
        o_cmd.addr = idx;
        o_cmd.data = r_color;
        o_cmd.last = step_wrap & row_wrap & pcol_wrap & prow_wrap;
        o_push     = 1'b0;

        case (r_mode)
            MODE_PLAIN: begin
                wr_do = 1'b1;
            end
            MODE_PATTERN: begin
                if (i_cfg.repl != '0) begin
                    if (r_color != '0) begin
                        wr_do    = 1'b1;
                        wr_color = i_cfg.repl;
                    end else if (!i_cfg.ovl) begin
                        wr_do    = 1'b1;
                        wr_color = '0;
                    end
                end else if (!i_cfg.ovl || r_color != '0) begin
                    wr_do = 1'b1;
                end
            end
            MODE_EMIT: begin
                o_cmd.op = in_store ? OP_READ : OP_ZERO;
                o_push   = consume;
            end
            default: begin
                wr_do = 1'b0;
            end
        endcase

        if (wr_do) begin
            o_cmd.data = wr_color;
            o_push     = consume && in_range && in_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (consume) begin
            r_v <= 1'b0;
        end
        if (accept) begin
            r_mode  <= i_mode;
            r_x     <= i_pixel_x;
            r_y     <= i_pixel_y;
            r_pc    <= i_pattern_col;
            r_pr    <= i_pattern_row;
            r_color <= i_pixel_color;
        end
    end

    // chain scan position with running panel origins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_step <= '0;
            r_row  <= '0;
            r_pcol <= '0;
            r_prow <= '0;
            r_x0   <= '0;
            r_y0   <= '0;
        end else if (emit) begin
            if (!step_wrap) begin
                r_step <= r_step + 6'd1;
            end else begin
                r_step <= '0;
                if (!row_wrap) begin
                    r_row <= r_row + 6'd1;
                end else begin
                    r_row <= '0;
                    if (!pcol_wrap) begin
                        r_pcol <= r_pcol + 4'd1;
                        r_x0   <= r_x0 + {3'b0, i_cfg.pw};
                    end else begin
                        r_pcol <= '0;
                        r_x0   <= '0;
                        if (!prow_wrap) begin
                            r_prow <= r_prow + 4'd1;
                            r_y0   <= r_y0 + {3'b0, i_cfg.ph};
                        end else begin
                            r_prow <= '0;
                            r_y0   <= '0;
                        end
                    end
                end
            end
        end
    end
endmodule

>>> rtl/lps_queue.sv
// short command queue between front and back
module lps_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lps_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output lps_pkg::t_cmd o_head
);
    import lps_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [CW-1:0] r_cnt;

    assign o_full  = r_cnt == CW'(QUEUE_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_head  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + PW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (i_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end
endmodule

>>> rtl/lps_back.sv
// back end: frame memory, clearing pass and result buffer
module lps_back #(
    parameter int MAX_PIXELS = lps_pkg::MAX_PIXELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_empty,
    input  lps_pkg::t_cmd       i_head,
    output logic                o_pop,
    output lps_pkg::t_back_stat o_stat,
    output logic                o_valid,
    input  logic                i_out_ready,
    output logic [23:0]         o_led_color,
    output logic                o_frame_last
);
    import lps_pkg::*;

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;

    logic               r_clr;
    logic [AW-1:0]      r_clr_addr;
    logic               r_rd_pend;
    logic               r_rd_zero;
    logic               r_rd_last;
    logic [COLOR_W-1:0] r_ob_data [2];
    logic               r_ob_last [2];
    logic               r_ob_wp;
    logic               r_ob_rp;
    logic [1:0]         r_ob_cnt;

    logic               head_wr;
    logic               fire;
    logic               room;
    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic [COLOR_W-1:0] ram_wdata;
    logic [COLOR_W-1:0] ram_rdata;

    assign head_wr   = i_head.op == OP_WRITE;
    assign fire      = (r_ob_cnt != 2'd0) && i_out_ready;
    assign room      = ({1'b0, r_ob_cnt} + {2'b0, r_rd_pend}) < (3'd2 + {2'b0, fire});
    assign o_pop     = !i_empty && !r_clr && (head_wr || room);
    assign ram_we    = r_clr || (o_pop && head_wr);
    assign ram_addr  = r_clr ? r_clr_addr : i_head.addr[AW-1:0];
    assign ram_wdata = r_clr ? '0 : i_head.data;

    assign o_stat.clearing = r_clr;
    assign o_valid         = r_ob_cnt != 2'd0;
    assign o_led_color     = r_ob_data[r_ob_rp];
    assign o_frame_last    = r_ob_last[r_ob_rp];

    lps_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_PIXELS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_rd_pend  <= 1'b0;
            r_ob_wp    <= 1'b0;
            r_ob_rp    <= 1'b0;
            r_ob_cnt   <= '0;
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAX_PIXELS - 1)) begin
                    r_clr <= 1'b0;
                end
            end
            r_rd_pend <= o_pop && !head_wr;
            if (r_rd_pend) begin
                r_ob_wp <= !r_ob_wp;
            end
            if (fire) begin
                r_ob_rp <= !r_ob_rp;
            end
            if (r_rd_pend && !fire) begin
                r_ob_cnt <= r_ob_cnt + 2'd1;
            end else if (fire && !r_rd_pend) begin
                r_ob_cnt <= r_ob_cnt - 2'd1;
            end
        end
        r_rd_zero <= i_head.op == OP_ZERO;
        r_rd_last <= i_head.last;
        if (r_rd_pend) begin
            r_ob_data[r_ob_wp] <= r_rd_zero ? '0 : ram_rdata;
            r_ob_last[r_ob_wp] <= r_rd_last;
        end
    end

    a_ob_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ob_cnt != 2'd3)
        else $error("result buffer count out of range");

    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_pop)
        else $error("queue popped during clearing pass");

    a_read_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_ob_cnt != 2'd2 || i_out_ready))
        else $error("read data arrives with result buffer full");

    a_clr_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_clr) && r_clr |-> !r_rd_pend)
        else $error("read pending during clearing pass");
endmodule

>>> rtl/led_panel_frame_scanner.sv
// top level: register port, geometry, front, queue and back of the frame scanner
//
// Frame store and chain scanner for a tiled LED matrix. Writes (plain and
// pattern pixels) and emit requests are taken at up to one transfer per clock;
// the front maps each item to a store address with one multiply, a four entry
// queue decouples it from the back, which does one frame memory access per
// cycle, so the sustained rate is one item per cycle while results are taken;
// an emitted pixel passes the front register, queue, memory read and result
// buffer. After reset the store is swept to zero one word per cycle; no item
// is accepted until all MAX_PIXELS words are cleared, though register accesses
// work throughout. Geometry register writes restart the scan at the first LED.
module led_panel_frame_scanner #(
    parameter int MAX_PIXELS = lps_pkg::MAX_PIXELS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lps_pkg::PADDR_W-1:0] paddr,
    input  logic [lps_pkg::PDATA_W-1:0] pwdata,
    output logic [lps_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_mode,
    input  logic [9:0]                  i_pixel_x,
    input  logic [9:0]                  i_pixel_y,
    input  logic [7:0]                  i_pattern_col,
    input  logic [7:0]                  i_pattern_row,
    input  logic [23:0]                 i_pixel_color,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [23:0]                 o_led_color,
    output logic                        o_frame_last
);
    import lps_pkg::*;

    logic [6:0]         r_pw;
    logic [6:0]         r_ph;
    logic [4:0]         r_pa;
    logic [4:0]         r_pd;
    logic               r_serp;
    logic               r_l2r;
    logic [COLOR_W-1:0] r_repl;
    logic               r_ovl;
    logic [10:0]        r_w;
    logic [10:0]        r_h;
    logic [10:0]        n_w;
    logic [10:0]        n_h;

    t_reg       reg_sel;
    logic       cfg_we;
    logic       restart;
    logic [6:0] pw_eff;
    logic [6:0] ph_eff;
    logic [4:0] pa_eff;
    logic [4:0] pd_eff;
    t_cfg       cfg;

    logic       front_ready;
    logic       q_push;
    t_cmd       q_cmd;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    t_cmd       q_head;
    t_back_stat back_stat;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[4:2]);
    assign cfg_we  = psel && penable && pwrite && pready;
    assign restart = cfg_we && (reg_sel == REG_PANEL_WIDTH || reg_sel == REG_PANEL_HEIGHT
                     || reg_sel == REG_PANELS_ACROSS || reg_sel == REG_PANELS_DOWN);

    assign pw_eff = f_clamp(r_pw, 7'd64);
    assign ph_eff = f_clamp(r_ph, 7'd64);
    assign pa_eff = 5'(f_clamp({2'b0, r_pa}, 7'd16));
    assign pd_eff = 5'(f_clamp({2'b0, r_pd}, 7'd16));
    assign n_w    = {4'b0, pw_eff} * {6'b0, pa_eff};
    assign n_h    = {4'b0, ph_eff} * {6'b0, pd_eff};

    always_comb begin
        cfg.pw   = pw_eff;
        cfg.ph   = ph_eff;
        cfg.pa   = pa_eff;
        cfg.pd   = pd_eff;
        cfg.w    = r_w;
        cfg.h    = r_h;
        cfg.serp = r_serp;
        cfg.l2r  = r_l2r;
        cfg.repl = r_repl;
        cfg.ovl  = r_ovl;
    end

    always_comb begin
        unique case (reg_sel)
            REG_PANEL_WIDTH:   prdata = PDATA_W'(r_pw);
            REG_PANEL_HEIGHT:  prdata = PDATA_W'(r_ph);
            REG_PANELS_ACROSS: prdata = PDATA_W'(r_pa);
            REG_PANELS_DOWN:   prdata = PDATA_W'(r_pd);
            REG_SERPENTINE:    prdata = PDATA_W'(r_serp);
            REG_FIRST_ROW_L2R: prdata = PDATA_W'(r_l2r);
            REG_REPLACE_COLOR: prdata = PDATA_W'(r_repl);
            REG_OVERLAY_ONLY:  prdata = PDATA_W'(r_ovl);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pw   <= 7'd8;
            r_ph   <= 7'd8;
            r_pa   <= 5'd1;
            r_pd   <= 5'd1;
            r_serp <= 1'b0;
            r_l2r  <= 1'b1;
            r_repl <= '0;
            r_ovl  <= 1'b0;
            r_w    <= 11'd8;
            r_h    <= 11'd8;
        end else begin
            r_w <= n_w;
            r_h <= n_h;
            if (cfg_we) begin
                unique case (reg_sel)
                    REG_PANEL_WIDTH:   r_pw   <= pwdata[6:0];
                    REG_PANEL_HEIGHT:  r_ph   <= pwdata[6:0];
                    REG_PANELS_ACROSS: r_pa   <= pwdata[4:0];
                    REG_PANELS_DOWN:   r_pd   <= pwdata[4:0];
                    REG_SERPENTINE:    r_serp <= pwdata[0];
                    REG_FIRST_ROW_L2R: r_l2r  <= pwdata[0];
                    REG_REPLACE_COLOR: r_repl <= pwdata[COLOR_W-1:0];
                    REG_OVERLAY_ONLY:  r_ovl  <= pwdata[0];
                    default:           r_ovl  <= r_ovl;
                endcase
            end
        end
    end

    // no transfers while the store is being cleared
    assign o_ready = front_ready && !back_stat.clearing;

    lps_front #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_restart     (restart),
        .i_valid       (i_valid && !back_stat.clearing),
        .o_ready       (front_ready),
        .i_mode        (i_mode),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_pattern_col (i_pattern_col),
        .i_pattern_row (i_pattern_row),
        .i_pixel_color (i_pixel_color),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (q_cmd)
    );

    lps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    lps_back #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_stat       (back_stat),
        .o_valid      (o_valid),
        .i_out_ready  (i_ready),
        .o_led_color  (o_led_color),
        .o_frame_last (o_frame_last)
    );
endmodule
